// ----- rtl/chcv_pkg.sv -----
// Census Hamming cost volume: shared widths, constants, command type and helpers.
// No dependencies; most other files of the block take their names from here.
package chcv_pkg;

  localparam int unsigned MAX_DISP_DEF = 64;

  localparam int unsigned LOW_W    = 64;
  localparam int unsigned HIGH_W   = 17;
  localparam int unsigned CENSUS_W = LOW_W + HIGH_W;
  localparam int unsigned DISP_W   = 6;
  localparam int unsigned HAM_W    = 7;
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CNT_W    = 7;

  // APB register map
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned RIDX_W  = ADDR_W - 2;
  localparam logic [RIDX_W-1:0] REG_NUM_DISP = 1'b0;
  localparam logic [CFG_W-1:0]  NUM_DISP_RST = 7'd64;

  // norm = floor(h * 2^16 / 121) = (h * ceil(2^32 / 121)) >> 16, exact for h < 1057
  localparam int unsigned SCALE_DIV   = 121;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = 26;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (FRAC_BITS + RECIP_SHIFT)) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  typedef struct packed {
    logic              start;  // input beat accepted this cycle
    logic              issue;  // history read for disp issued this cycle
    logic [DISP_W-1:0] disp;
    logic              last;   // disp is the final level of the pixel
  } cmd_t;

  function automatic logic [HAM_W-1:0] popcount(input logic [CENSUS_W-1:0] v);
    logic [HAM_W-1:0] n;
    n = '0;
    for (int i = 0; i < CENSUS_W; i++) begin
      n = n + HAM_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [NORM_W-1:0] norm_of(input logic [HAM_W-1:0] h);
    logic [HAM_W+RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, h} * {{HAM_W{1'b0}}, RECIP};
    return p[RECIP_SHIFT +: NORM_W];
  endfunction

endpackage

// ----- rtl/chcv_in_if.sv -----
// Input channel of the census cost block: one pixel beat (left and right census).
// Depends on chcv_pkg for field widths.
interface chcv_in_if;
  logic                      valid;
  logic                      ready;
  logic [chcv_pkg::LOW_W-1:0]  left_census_low;
  logic [chcv_pkg::HIGH_W-1:0] left_census_high;
  logic [chcv_pkg::LOW_W-1:0]  right_census_low;
  logic [chcv_pkg::HIGH_W-1:0] right_census_high;
  logic                      first_in_row;

  modport source (
    output valid, left_census_low, left_census_high, right_census_low,
           right_census_high, first_in_row,
    input  ready
  );
  modport sink (
    input  valid, left_census_low, left_census_high, right_census_low,
           right_census_high, first_in_row,
    output ready
  );
endinterface

// ----- rtl/chcv_out_if.sv -----
// Output channel of the census cost block: one cost beat per disparity level.
// Depends on chcv_pkg for field widths.
interface chcv_out_if;
  logic                        valid;
  logic                        ready;
  logic [chcv_pkg::DISP_W-1:0] disparity;
  logic [chcv_pkg::HAM_W-1:0]  hamming_count;
  logic [chcv_pkg::NORM_W-1:0] norm_cost;
  logic                        last_of_pixel;

  modport source (
    output valid, disparity, hamming_count, norm_cost, last_of_pixel,
    input  ready
  );
  modport sink (
    input  valid, disparity, hamming_count, norm_cost, last_of_pixel,
    output ready
  );
endinterface

// ----- rtl/census_hamming_cost_volume_top.sv -----
// Top level of the census Hamming cost volume block: APB register, controller,
// datapath. Depends on chcv_pkg, chcv_in_if, chcv_out_if, chcv_ctrl, chcv_datapath.
//
//  channel  | dir | beat                                         | handshake
//  ---------+-----+----------------------------------------------+-----------------
//  in_i     | in  | left/right census low+high, first_in_row     | valid & ready
//  out_o    | out | disparity, hamming_count, norm_cost, last    | valid & ready
//  apb      | in  | num_disparities at byte 0 (7 bits)           | psel&penable&pwrite
//
// One pixel beat yields N cost beats, N = num_disparities clamped to 1..MAX_DISP.
// The disparity sequencer issues one history-RAM read per cycle while the output
// does not stall; each cost then passes the RAM read, popcount and output registers.
// Output stalls freeze the whole read pipe; a new pixel is taken while the last
// costs of the previous one are still draining. Reset clears control state only:
// the history RAM needs no clearing pass, a fill count masks unwritten entries.
module census_hamming_cost_volume_top #(
  parameter int unsigned MAX_DISP = chcv_pkg::MAX_DISP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [chcv_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [chcv_pkg::APB_DW-1:0]   pwdata_i,
  output logic [chcv_pkg::APB_DW-1:0]   prdata_o,
  output logic                          pready_o,
  chcv_in_if.sink                       in_i,
  chcv_out_if.source                    out_o
);

  logic [chcv_pkg::CFG_W-1:0]  num_disp_q;
  logic [chcv_pkg::RIDX_W-1:0] reg_idx;
  logic                        reg_wr;
  chcv_pkg::cmd_t              cmd;
  logic                        adv;

  // ---- APB register: write on access phase, no wait states ----
  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[chcv_pkg::ADDR_W-1:2];
  assign reg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_disp_q <= chcv_pkg::NUM_DISP_RST;
    end else if (reg_wr && (reg_idx == chcv_pkg::REG_NUM_DISP)) begin
      num_disp_q <= pwdata_i[chcv_pkg::CFG_W-1:0];
    end
  end

  // addresses past the map read as zero
  always_comb begin
    prdata_o = '0;
    if (reg_idx == chcv_pkg::REG_NUM_DISP) begin
      prdata_o = chcv_pkg::APB_DW'(num_disp_q);
    end
  end

  // ---- controller: pixel accept and disparity sequencing ----
  chcv_ctrl #(
    .MAX_DISP (MAX_DISP)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .cfg_num_disp_i (num_disp_q),
    .adv_i          (adv),
    .cmd_o          (cmd)
  );

  // ---- datapath: history ring, popcount, scaling, output register ----
  chcv_datapath #(
    .MAX_DISP (MAX_DISP)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .left_census_low_i   (in_i.left_census_low),
    .left_census_high_i  (in_i.left_census_high),
    .right_census_low_i  (in_i.right_census_low),
    .right_census_high_i (in_i.right_census_high),
    .first_in_row_i      (in_i.first_in_row),
    .adv_o               (adv),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .disparity_o         (out_o.disparity),
    .hamming_count_o     (out_o.hamming_count),
    .norm_cost_o         (out_o.norm_cost),
    .last_of_pixel_o     (out_o.last_of_pixel)
  );

endmodule

// ----- rtl/chcv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chcv_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/chcv_ctrl.sv -----
// Controller of the census cost block: accepts a pixel, then steps the disparity
// level once per free pipeline slot. Depends on chcv_pkg (cmd_t, widths).
module chcv_ctrl #(
  parameter int unsigned MAX_DISP = chcv_pkg::MAX_DISP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [chcv_pkg::CFG_W-1:0]   cfg_num_disp_i,
  input  logic                         adv_i,
  output chcv_pkg::cmd_t               cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [chcv_pkg::DISP_W-1:0]   disp_q, disp_d;
  logic [chcv_pkg::DISP_W-1:0]   last_disp_q, last_disp_d;
  logic [chcv_pkg::DISP_W-1:0]   last_idx;
  logic                          accept;

  // effective count minus one: zero reads as one, above MAX_DISP saturates
  always_comb begin
    if (cfg_num_disp_i == '0) begin
      last_idx = '0;
    end else if (cfg_num_disp_i > chcv_pkg::CFG_W'(MAX_DISP)) begin
      last_idx = chcv_pkg::DISP_W'(MAX_DISP - 1);
    end else begin
      last_idx = chcv_pkg::DISP_W'(cfg_num_disp_i - chcv_pkg::CFG_W'(1));
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  assign cmd_o.start = accept;
  assign cmd_o.issue = (state_q == ST_RUN) && adv_i;
  assign cmd_o.disp  = disp_q;
  assign cmd_o.last  = (disp_q == last_disp_q);

  always_comb begin
    state_d     = state_q;
    disp_d      = disp_q;
    last_disp_d = last_disp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_RUN;
          disp_d      = '0;
          last_disp_d = last_idx;
        end
      end
      ST_RUN: begin
        if (cmd_o.issue) begin
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else begin
            disp_d = disp_q + chcv_pkg::DISP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      disp_q      <= '0;
      last_disp_q <= '0;
    end else begin
      state_q     <= state_d;
      disp_q      <= disp_d;
      last_disp_q <= last_disp_d;
    end
  end

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue && !cmd_o.last |=>
      cmd_o.disp == chcv_pkg::DISP_W'($past(cmd_o.disp) + chcv_pkg::DISP_W'(1)))
    else $error("disparity did not step after issue");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue && cmd_o.last |=> in_ready_o)
    else $error("not ready after last level issued");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> cmd_o.disp == '0 && !in_ready_o)
    else $error("pixel start did not begin at level zero");

endmodule

// ----- rtl/chcv_datapath.sv -----
// Datapath of the census cost block: right-census ring buffer, history read,
// popcount and 1/121 scaling in a three-stage stallable pipe.
// Depends on chcv_pkg and chcv_ram.
module chcv_datapath #(
  parameter int unsigned MAX_DISP = chcv_pkg::MAX_DISP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  chcv_pkg::cmd_t                cmd_i,
  input  logic [chcv_pkg::LOW_W-1:0]    left_census_low_i,
  input  logic [chcv_pkg::HIGH_W-1:0]   left_census_high_i,
  input  logic [chcv_pkg::LOW_W-1:0]    right_census_low_i,
  input  logic [chcv_pkg::HIGH_W-1:0]   right_census_high_i,
  input  logic                          first_in_row_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [chcv_pkg::DISP_W-1:0]   disparity_o,
  output logic [chcv_pkg::HAM_W-1:0]    hamming_count_o,
  output logic [chcv_pkg::NORM_W-1:0]   norm_cost_o,
  output logic                          last_of_pixel_o
);

  localparam int unsigned AW    = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned CW    = chcv_pkg::CNT_W;
  localparam int unsigned VW    = chcv_pkg::CENSUS_W;

  // history bookkeeping
  logic [AW-1:0] wp_q;
  logic [CW-1:0] nvalid_q;   // entries written since last row start, saturates
  logic          row_seen_q; // a row start has occurred since reset
  logic [VW-1:0] left_q;

  // read side
  logic          hit;
  logic [CW-1:0] off;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rdata;
  logic          adv;

  // stage 1: RAM data
  logic                        v1_q;
  logic [VW-1:0]               left1_q;
  logic                        zero1_q;
  logic [chcv_pkg::DISP_W-1:0] d1_q;
  logic                        last1_q;
  // stage 2: popcount
  logic                        v2_q;
  logic [chcv_pkg::HAM_W-1:0]  h2_q;
  logic [chcv_pkg::DISP_W-1:0] d2_q;
  logic                        last2_q;
  // stage 3: output register
  logic                        v3_q;
  logic [chcv_pkg::HAM_W-1:0]  h3_q;
  logic [chcv_pkg::NORM_W-1:0] n3_q;
  logic [chcv_pkg::DISP_W-1:0] d3_q;
  logic                        last3_q;

  assign adv   = !v3_q || out_ready_i;
  assign adv_o = adv;

  // levels past the written entries clamp to the row-start entry,
  // or read as zero when no row start has been seen yet
  assign hit   = {1'b0, cmd_i.disp} < nvalid_q;
  assign off   = hit ? {1'b0, cmd_i.disp} : (nvalid_q - CW'(1));
  assign raddr = wp_q - off[AW-1:0];

  chcv_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start),
    .waddr_i (wp_q + AW'(1)),
    .wdata_i ({right_census_high_i, right_census_low_i}),
    .re_i    (adv),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      nvalid_q   <= '0;
      row_seen_q <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        wp_q <= wp_q + AW'(1);
        if (first_in_row_i) begin
          nvalid_q   <= CW'(1);
          row_seen_q <= 1'b1;
        end else if (nvalid_q != CW'(MAX_DISP)) begin
          nvalid_q <= nvalid_q + CW'(1);
        end
      end
      if (adv) begin
        v1_q <= cmd_i.issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      left_q <= {left_census_high_i, left_census_low_i};
    end
    if (adv) begin
      left1_q <= left_q;
      zero1_q <= !hit && !row_seen_q;
      d1_q    <= cmd_i.disp;
      last1_q <= cmd_i.last;
      h2_q    <= chcv_pkg::popcount(left1_q ^ (zero1_q ? '0 : rdata));
      d2_q    <= d1_q;
      last2_q <= last1_q;
      h3_q    <= h2_q;
      n3_q    <= chcv_pkg::norm_of(h2_q);
      d3_q    <= d2_q;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign disparity_o     = d3_q;
  assign hamming_count_o = h3_q;
  assign norm_cost_o     = n3_q;
  assign last_of_pixel_o = last3_q;

  a_ham_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hamming_count_o <= chcv_pkg::HAM_W'(VW))
    else $error("hamming count above vector width");

  a_issue_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> nvalid_q != '0)
    else $error("history read with no entry written");

  a_nvalid_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nvalid_q <= CW'(MAX_DISP))
    else $error("history fill count beyond depth");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for census_hamming_cost_volume_top: pixel beats in,
// per-disparity cost beats out, checked against an in-bench cost predictor.
// Depends on chcv_pkg, chcv_in_if, chcv_out_if and the RTL top level.
module testbench;

  localparam int unsigned MAX_DISP_DEF = chcv_pkg::MAX_DISP_DEF;
  localparam int unsigned LOW_W        = chcv_pkg::LOW_W;
  localparam int unsigned HIGH_W       = chcv_pkg::HIGH_W;
  localparam int unsigned CENSUS_W     = chcv_pkg::CENSUS_W;
  localparam int unsigned DISP_W       = chcv_pkg::DISP_W;
  localparam int unsigned HAM_W        = chcv_pkg::HAM_W;
  localparam int unsigned NORM_W       = chcv_pkg::NORM_W;
  localparam int unsigned CFG_W        = chcv_pkg::CFG_W;
  localparam int unsigned APB_DW       = chcv_pkg::APB_DW;
  localparam int unsigned ADDR_W       = chcv_pkg::ADDR_W;
  localparam int unsigned FRAC_BITS    = chcv_pkg::FRAC_BITS;
  localparam int unsigned SCALE_DIV    = chcv_pkg::SCALE_DIV;

  localparam int unsigned DISP_LEVELS = MAX_DISP_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;  // cycles with no beat on either channel
  localparam int unsigned HOLD_CYCLES = 300;   // long output stall in the pressure test
  localparam int unsigned DRAIN_CYCLES = 8;    // read pipe is 3 deep; margin on top
  localparam int unsigned MAX_REPORTS = 50;
  localparam logic [ADDR_W-1:0] NUM_DISP_ADDR = {chcv_pkg::REG_NUM_DISP, 2'b00};

  localparam logic [CENSUS_W-1:0] CENSUS_ZERO = '0;
  localparam logic [CENSUS_W-1:0] CENSUS_ONES = '1;
  localparam logic [CENSUS_W-1:0] CENSUS_HIGH = {{HIGH_W{1'b1}}, {LOW_W{1'b0}}};
  localparam logic [CENSUS_W-1:0] CENSUS_LOW  = {{HIGH_W{1'b0}}, {LOW_W{1'b1}}};

  typedef struct packed {
    logic [LOW_W-1:0]  left_low;
    logic [HIGH_W-1:0] left_high;
    logic [LOW_W-1:0]  right_low;
    logic [HIGH_W-1:0] right_high;
    logic              first_in_row;
  } pixel_t;

  typedef struct packed {
    logic [DISP_W-1:0] disparity;
    logic [HAM_W-1:0]  hamming;
    logic [NORM_W-1:0] norm;
    logic              last;
  } cost_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              apb_psel;
  logic              apb_penable;
  logic              apb_pwrite;
  logic [ADDR_W-1:0] apb_paddr;
  logic [APB_DW-1:0] apb_pwdata;
  logic [APB_DW-1:0] apb_prdata;
  logic              apb_pready;

  chcv_in_if  pixel_if ();
  chcv_out_if cost_if ();

  census_hamming_cost_volume_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (apb_psel),
    .penable_i (apb_penable),
    .pwrite_i  (apb_pwrite),
    .paddr_i   (apb_paddr),
    .pwdata_i  (apb_pwdata),
    .prdata_o  (apb_prdata),
    .pready_o  (apb_pready),
    .in_i      (pixel_if),
    .out_o     (cost_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: a mirror of the right-vector delay line and the disparity register.
  logic [CENSUS_W-1:0] right_hist [DISP_LEVELS];
  logic [CFG_W-1:0]    disp_count;
  cost_t               pending_costs[$];

  int unsigned errors = 0;      // cost side
  int unsigned cfg_errors = 0;  // register read-back
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req = 0;    // bumped by a test to request a long output stall
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // Update the delay line for one accepted pixel beat and queue its cost beats.
  function automatic void compute_pixel_costs(input pixel_t p);
    logic [CENSUS_W-1:0] left_vec;
    logic [CENSUS_W-1:0] right_vec;
    int unsigned levels;
    int unsigned ham;
    cost_t c;
    left_vec  = {p.left_high, p.left_low};
    right_vec = {p.right_high, p.right_low};
    // Row start clamps every earlier column to column 0.
    if (p.first_in_row) begin
      foreach (right_hist[k]) right_hist[k] = right_vec;
    end else begin
      for (int k = DISP_LEVELS - 1; k > 0; k--) right_hist[k] = right_hist[k-1];
      right_hist[0] = right_vec;
    end
    // Zero behaves as one level; anything above the depth saturates.
    if (disp_count == 0) levels = 1;
    else if (disp_count > DISP_LEVELS) levels = DISP_LEVELS;
    else levels = disp_count;
    for (int d = 0; d < levels; d++) begin
      ham = $countones(left_vec ^ right_hist[d]);
      c.disparity = DISP_W'(d);
      c.hamming   = HAM_W'(ham);
      c.norm      = NORM_W'((ham << FRAC_BITS) / SCALE_DIV);
      c.last      = (d == levels - 1);
      pending_costs.push_back(c);
    end
  endfunction

  function automatic pixel_t pixel_of(input logic [CENSUS_W-1:0] left_vec,
                                      input logic [CENSUS_W-1:0] right_vec,
                                      input logic first);
    pixel_t p;
    {p.left_high, p.left_low}   = left_vec;
    {p.right_high, p.right_low} = right_vec;
    p.first_in_row = first;
    return p;
  endfunction

  // Random pixel. Many left vectors are a lightly corrupted copy of the right vector
  // at some disparity, so costs cover the whole range instead of clustering near 40.
  function automatic pixel_t make_pixel(input logic first);
    pixel_t p;
    logic [CENSUS_W-1:0] right_vec;
    logic [CENSUS_W-1:0] base;
    logic [CENSUS_W-1:0] flips;
    int unsigned k;
    right_vec = {HIGH_W'($urandom), $urandom, $urandom};
    k = $urandom_range(DISP_LEVELS - 1);
    if (first || k == 0) base = right_vec;
    else base = right_hist[k-1];
    flips = '0;
    repeat ($urandom_range(4)) flips[$urandom_range(CENSUS_W - 1)] = 1'b1;
    case ($urandom_range(9))
      0, 1, 2, 3: p = pixel_of({HIGH_W'($urandom), $urandom, $urandom}, right_vec, first);
      4, 5, 6, 7: p = pixel_of(base ^ flips, right_vec, first);
      8:          p = pixel_of(~base, right_vec, first);
      default: begin
        p = pixel_of($urandom_range(1) ? CENSUS_ONES : CENSUS_ZERO,
                     $urandom_range(1) ? CENSUS_ONES : CENSUS_ZERO, first);
      end
    endcase
    return p;
  endfunction

  function automatic logic [CFG_W-1:0] pick_disp_count();
    case ($urandom_range(7))
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd0;
      3:       return CFG_W'($urandom_range(65, 127));
      default: return CFG_W'($urandom_range(2, 16));
    endcase
  endfunction

  // One pixel beat. valid stays high after acceptance so back-to-back beats never
  // see a low/high pair of assignments in one step; idle cycles lower it first.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pixel_if.valid             <= 1'b1;
    pixel_if.left_census_low   <= p.left_low;
    pixel_if.left_census_high  <= p.left_high;
    pixel_if.right_census_low  <= p.right_low;
    pixel_if.right_census_high <= p.right_high;
    pixel_if.first_in_row      <= p.first_in_row;
    do @(posedge clk_i); while (!pixel_if.ready);
    compute_pixel_costs(p);
  endtask

  // Stop offering pixels and wait until every queued cost beat has come out.
  task automatic drain_costs();
    pixel_if.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of the disparity count, then a read-back of the same register.
  task automatic write_disp_count(input logic [CFG_W-1:0] value);
    apb_psel    <= 1'b1;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b1;
    apb_paddr   <= NUM_DISP_ADDR;
    apb_pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    disp_count = value;
    apb_penable <= 1'b0;
    apb_pwrite  <= 1'b0;
    @(posedge clk_i);
    apb_penable <= 1'b1;
    do @(posedge clk_i); while (!apb_pready);
    if (apb_prdata !== APB_DW'(value)) begin
      cfg_errors++;
      $display("%0t: num_disparities readback expected %0d got %0d",
               $realtime, value, apb_prdata);
    end
    apb_psel    <= 1'b0;
    apb_penable <= 1'b0;
  endtask

  // Field extremes, an unloaded delay line, row starts and the count corner values.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Reset count of 64; nothing loaded yet, so deeper entries compare as zero.
    send_pixel(pixel_of(CENSUS_ONES, CENSUS_ONES, 1'b0));
    send_pixel(pixel_of(CENSUS_ZERO, CENSUS_ZERO, 1'b0));
    send_pixel(pixel_of(CENSUS_HIGH, CENSUS_ZERO, 1'b1));
    send_pixel(pixel_of(CENSUS_LOW, CENSUS_LOW, 1'b1));
    repeat (4) send_pixel(make_pixel(1'b0));
    send_pixel(pixel_of(CENSUS_ZERO, CENSUS_ONES, 1'b0));
    drain_costs();
    write_disp_count(7'd1);
    send_pixel(make_pixel(1'b1));
    send_pixel(make_pixel(1'b0));
    drain_costs();
    write_disp_count(7'd0);      // behaves as a single level
    send_pixel(make_pixel(1'b0));
    send_pixel(make_pixel(1'b1));
    drain_costs();
    write_disp_count(7'd127);    // saturates to the delay-line depth
    send_pixel(make_pixel(1'b0));
    send_pixel(make_pixel(1'b0));
    drain_costs();
    write_disp_count(7'd65);
    send_pixel(make_pixel(1'b0));
    drain_costs();
    write_disp_count(7'd64);
    send_pixel(make_pixel(1'b1));
    drain_costs();
  endtask

  // Rows of random length with random content; a few stray row starts as noise.
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct);
    int unsigned row_left;
    logic first;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      write_disp_count(pick_disp_count());
      row_left = 0;
      repeat (28) begin
        first = (row_left == 0) || ($urandom_range(99) < 3);
        if (first) row_left = $urandom_range(1, 40);
        row_left--;
        send_pixel(make_pixel(first));
      end
      drain_costs();
    end
  endtask

  // Output held off for a long stretch while pixels keep coming: the read pipe
  // freezes and the input must stall rather than drop or overwrite a beat.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_disp_count(7'd8);
    hold_req++;
    send_pixel(make_pixel(1'b1));
    repeat (29) send_pixel(make_pixel(1'b0));
    drain_costs();
  endtask

  // Output side: ready with random gaps, or held low while a stall is counted down.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_if.ready <= 1'b0;
      hold_seen     <= 0;
      hold_left     <= 0;
    end else if (hold_seen != hold_req) begin
      cost_if.ready <= 1'b0;
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      cost_if.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      cost_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each cost beat is checked against the oldest predicted one.
  always @(posedge clk_i) begin : check_cost
    cost_t want;
    if (rst_ni && cost_if.valid && cost_if.ready) begin
      if (pending_costs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected cost beat, expected none got disparity %0d",
                   $realtime, cost_if.disparity);
      end else begin
        want = pending_costs.pop_front();
        if (cost_if.disparity !== want.disparity ||
            cost_if.hamming_count !== want.hamming ||
            cost_if.norm_cost !== want.norm ||
            cost_if.last_of_pixel !== want.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: cost mismatch expected d=%0d h=%0d n=%0d l=%0b got d=%0d h=%0d n=%0d l=%0b",
                     $realtime, want.disparity, want.hamming, want.norm, want.last,
                     cost_if.disparity, cost_if.hamming_count, cost_if.norm_cost,
                     cost_if.last_of_pixel);
        end
      end
    end
  end

  // Watchdog: ends the run once neither channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((pixel_if.valid && pixel_if.ready) || (cost_if.valid && cost_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("census_hamming_cost_volume_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    disp_count    = chcv_pkg::NUM_DISP_RST;
    foreach (right_hist[k]) right_hist[k] = '0;
    rst_ni                     = 1'b0;
    apb_psel                   = 1'b0;
    apb_penable                = 1'b0;
    apb_pwrite                 = 1'b0;
    apb_paddr                  = '0;
    apb_pwdata                 = '0;
    pixel_if.valid             = 1'b0;
    pixel_if.left_census_low   = '0;
    pixel_if.left_census_high  = '0;
    pixel_if.right_census_low  = '0;
    pixel_if.right_census_high = '0;
    pixel_if.first_in_row      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(7, 80);
    test_random_traffic(80, 7);
    test_backpressure();
    test_random_traffic(0, 0);

    if (errors == 0 && cfg_errors == 0 && pending_costs.size() == 0) begin
      $display("census_hamming_cost_volume_top verification clean");
    end else begin
      $display("census_hamming_cost_volume_top verification failed");
    end
    $finish;
  end

endmodule
